@@ rtl/core/m4inv_pkg.sv @@
// shared types, constants, tables and float helpers of the 4x4 inverse core
package m4inv_pkg;

    localparam int SCR_DEPTH = 32;
    localparam int SCR_AW    = 5;

    localparam logic [4:0] A_ACC = 5'd28;
    localparam logic [4:0] A_T   = 5'd29;
    localparam logic [4:0] A_INV = 5'd30;
    localparam logic [4:0] A_ONE = 5'd31;

    localparam logic [31:0] F_ONE     = 32'h3F80_0000;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    localparam logic [1:0] MODE_INV = 2'd0;
    localparam logic [1:0] MODE_DIV = 2'd1;

    typedef logic signed [11:0] t_exp;

    typedef enum logic [2:0] {
        OP_MUL  = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_DIV  = 3'd3,
        OP_EMIT = 3'd4
    } t_op;

    typedef struct packed {
        logic       rd;
        logic       go;
        logic       wr;
        logic       emit;
        logic       ld;
        t_op        op;
        logic [4:0] ra;
        logic [4:0] rb;
        logic [4:0] dst;
        logic       nega;
        logic [3:0] ld_addr;
        logic [3:0] idx;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_stat;

    typedef struct packed {
        logic        sgn;
        t_exp        ex;
        logic [23:0] man;
        logic        zero;
        logic        inf;
        logic        nan;
    } t_unp;

    localparam logic [3:0] MINOR_TAB [12][4] = '{
        '{0,5,1,4}, '{0,6,2,4}, '{0,7,3,4}, '{1,6,2,5}, '{1,7,3,5}, '{2,7,3,6},
        '{8,13,9,12}, '{8,14,10,12}, '{8,15,11,12}, '{9,14,10,13}, '{9,15,11,13},
        '{10,15,11,14}
    };

    localparam logic [3:0] DETK_TAB [4][2] = '{'{2,9}, '{3,8}, '{4,7}, '{5,6}};
    localparam logic [3:0] DETK_SUB = 4'b0100;

    localparam logic [3:0] DET_TERM [24][4] = '{
        '{12,9,6,3}, '{8,13,6,3}, '{12,5,10,3}, '{4,13,10,3}, '{8,5,14,3}, '{4,9,14,3},
        '{12,9,2,7}, '{8,13,2,7}, '{12,1,10,7}, '{0,13,10,7}, '{8,1,14,7}, '{0,9,14,7},
        '{12,5,2,11}, '{4,13,2,11}, '{12,1,6,11}, '{0,13,6,11}, '{4,1,14,11},
        '{0,5,14,11},
        '{8,5,2,15}, '{4,9,2,15}, '{8,1,6,15}, '{0,9,6,15}, '{4,1,10,15}, '{0,5,10,15}
    };
    localparam logic [23:0] DET_NEG = 24'h666666;

    localparam logic [3:0] ADJ_TAB [16][6] = '{
        '{5,11,6,10,7,9}, '{1,11,2,10,3,9}, '{13,5,14,4,15,3}, '{9,5,10,4,11,3},
        '{4,11,6,8,7,7}, '{0,11,2,8,3,7}, '{12,5,14,2,15,1}, '{8,5,10,2,11,1},
        '{4,10,5,8,7,6}, '{0,10,1,8,3,6}, '{12,4,13,2,15,0}, '{8,4,9,2,11,0},
        '{4,9,5,7,6,6}, '{0,9,1,7,2,6}, '{12,3,13,1,14,0}, '{8,3,9,1,10,0}
    };
    localparam logic [15:0] ADJ_NEG = 16'h5A5A;

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       hit;
        n   = 5'd27;
        hit = 1'b0;
        for (int k = 26; k >= 0; k--) begin
            if (!hit && v[k]) begin
                n   = 5'(26 - k);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic t_unp unpack(input logic [31:0] a, input logic norm);
        t_unp       u;
        logic [4:0] lz;
        u.sgn  = a[31];
        u.nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        u.inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        u.zero = (a[30:0] == 31'd0);
        if (a[30:23] == 8'd0) begin
            u.man = {1'b0, a[22:0]};
            u.ex  = 12'sd1;
        end else begin
            u.man = {1'b1, a[22:0]};
            u.ex  = $signed({4'b0, a[30:23]});
        end
        lz = lzc27({u.man, 3'b000});
        if (norm && !u.zero) begin
            u.man = u.man << lz;
            u.ex  = u.ex - $signed({7'b0, lz});
        end
        return u;
    endfunction

    // m[26] is the leading bit when ex >= 1, m[0] carries sticky
    function automatic logic [31:0] round_pack(input logic sgn, input t_exp ex,
                                               input logic [26:0] m);
        logic [26:0] mm;
        logic [26:0] mask;
        logic [11:0] sh;
        logic [24:0] r;
        logic        inc;
        t_exp        e2;
        logic [22:0] frac;
        mm = m;
        e2 = ex;
        sh = 12'(12'sd1 - ex);
        mask = ~({27{1'b1}} << sh[4:0]);
        if (ex < 12'sd1) begin
            if (sh > 12'd27) begin
                mm = {26'd0, |m};
            end else begin
                mm = (m >> sh[4:0]) | {26'd0, |(m & mask)};
            end
            e2 = 12'sd0;
        end
        inc = mm[2] & (mm[1] | mm[0] | mm[3]);
        r   = {1'b0, mm[26:3]} + {24'd0, inc};
        if (r[24]) begin
            e2 = e2 + 12'sd1;
        end else if (e2 == 12'sd0 && r[23]) begin
            e2 = 12'sd1;
        end
        frac = r[24] ? r[23:1] : r[22:0];
        if (e2 >= 12'sd255) begin
            return {sgn, 8'hFF, 23'd0};
        end
        return {sgn, e2[7:0], frac};
    endfunction

endpackage

@@ rtl/core/m4inv_ram.sv @@
// generic scratch ram, one write port and two registered read ports
module m4inv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

@@ rtl/core/m4inv_fpmul.sv @@
// single-precision multiplier with registered product and result, round to nearest even
module m4inv_fpmul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_res
);

    m4inv_pkg::t_unp ua;
    m4inv_pkg::t_unp ub;
    logic [47:0]     r_p;
    m4inv_pkg::t_exp r_ex;
    logic            r_sgn;
    logic            r_nan;
    logic            r_inf;
    logic            r_zero;
    logic            r_v;
    logic [31:0]     n_res;

    assign ua = m4inv_pkg::unpack(i_a, 1'b1);
    assign ub = m4inv_pkg::unpack(i_b, 1'b1);

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_p    <= ua.man * ub.man;
            r_ex   <= ua.ex + ub.ex - 12'sd127;
            r_sgn  <= ua.sgn ^ ub.sgn;
            r_nan  <= ua.nan | ub.nan | (ua.inf & ub.zero) | (ua.zero & ub.inf);
            r_inf  <= ua.inf | ub.inf;
            r_zero <= ua.zero | ub.zero;
        end
        o_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v    <= i_go;
            o_done <= r_v;
        end
    end

    always_comb begin
        if (r_nan) begin
            n_res = m4inv_pkg::CANON_NAN;
        end else if (r_inf) begin
            n_res = {r_sgn, 8'hFF, 23'd0};
        end else if (r_zero) begin
            n_res = {r_sgn, 31'd0};
        end else if (r_p[47]) begin
            n_res = m4inv_pkg::round_pack(r_sgn, r_ex + 12'sd1, {r_p[47:22], |r_p[21:0]});
        end else begin
            n_res = m4inv_pkg::round_pack(r_sgn, r_ex, {r_p[46:21], |r_p[20:0]});
        end
    end

endmodule

@@ rtl/core/m4inv_fpadd.sv @@
// single-precision adder and subtractor with registered sum and result, round to nearest even
module m4inv_fpadd (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic        i_sub,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_res
);

    m4inv_pkg::t_unp ua;
    m4inv_pkg::t_unp ub;
    m4inv_pkg::t_unp x;
    m4inv_pkg::t_unp y;
    logic [11:0]     d;
    logic [26:0]     y27;
    logic [26:0]     ym;
    logic [27:0]     n_sum;
    logic [27:0]     r_sum;
    m4inv_pkg::t_exp r_ex;
    logic            r_sgn;
    logic            r_zsgn;
    logic            r_nan;
    logic            r_inf;
    logic            r_isgn;
    logic            r_v;
    logic [4:0]      lz;
    logic [31:0]     n_res;

    always_comb begin
        ua = m4inv_pkg::unpack(i_a, 1'b0);
        ub = m4inv_pkg::unpack(i_b, 1'b0);
        ub.sgn = ub.sgn ^ i_sub;
        if ({ub.ex, ub.man} > {ua.ex, ua.man}) begin
            x = ub;
            y = ua;
        end else begin
            x = ua;
            y = ub;
        end
        d   = 12'(x.ex - y.ex);
        y27 = {y.man, 3'b000};
        if (d > 12'd27) begin
            ym = {26'd0, |y.man};
        end else begin
            ym = (y27 >> d[4:0]) | {26'd0, |(y27 & ~({27{1'b1}} << d[4:0]))};
        end
        if (x.sgn ^ y.sgn) begin
            n_sum = {1'b0, x.man, 3'b000} - {1'b0, ym};
        end else begin
            n_sum = {1'b0, x.man, 3'b000} + {1'b0, ym};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_sum  <= n_sum;
            r_ex   <= x.ex;
            r_sgn  <= x.sgn;
            r_zsgn <= ua.zero & ub.zero & ua.sgn & ub.sgn;
            r_nan  <= ua.nan | ub.nan | (ua.inf & ub.inf & (ua.sgn != ub.sgn));
            r_inf  <= ua.inf | ub.inf;
            r_isgn <= ua.inf ? ua.sgn : ub.sgn;
        end
        o_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v    <= i_go;
            o_done <= r_v;
        end
    end

    assign lz = m4inv_pkg::lzc27(r_sum[26:0]);

    always_comb begin
        if (r_nan) begin
            n_res = m4inv_pkg::CANON_NAN;
        end else if (r_inf) begin
            n_res = {r_isgn, 8'hFF, 23'd0};
        end else if (r_sum == 28'd0) begin
            n_res = {r_zsgn, 31'd0};
        end else if (r_sum[27]) begin
            n_res = m4inv_pkg::round_pack(r_sgn, r_ex + 12'sd1,
                                          {r_sum[27:2], r_sum[1] | r_sum[0]});
        end else begin
            n_res = m4inv_pkg::round_pack(r_sgn, r_ex - $signed({7'b0, lz}),
                                          r_sum[26:0] << lz);
        end
    end

endmodule

@@ rtl/core/m4inv_fpdiv.sv @@
// single-precision divider, one quotient bit per cycle, round to nearest even
module m4inv_fpdiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_res
);

    m4inv_pkg::t_unp ua;
    m4inv_pkg::t_unp ub;
    logic [23:0]     r_mb;
    logic [25:0]     r_rem;
    logic [27:0]     r_q;
    logic [4:0]      r_cnt;
    logic            r_run;
    logic            r_fin;
    m4inv_pkg::t_exp r_ex;
    logic            r_sgn;
    logic            r_nan;
    logic            r_inf;
    logic            r_zero;
    logic            ge;
    logic [25:0]     diff;
    logic            st;
    logic [31:0]     n_res;

    assign ua   = m4inv_pkg::unpack(i_a, 1'b1);
    assign ub   = m4inv_pkg::unpack(i_b, 1'b1);
    assign ge   = r_rem >= {2'b00, r_mb};
    assign diff = ge ? r_rem - {2'b00, r_mb} : r_rem;
    assign st   = r_rem != 26'd0;

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_mb   <= ub.man;
            r_rem  <= {2'b00, ua.man};
            r_q    <= 28'd0;
            r_ex   <= ua.ex - ub.ex + 12'sd127;
            r_sgn  <= ua.sgn ^ ub.sgn;
            r_nan  <= ua.nan | ub.nan | (ua.zero & ub.zero) | (ua.inf & ub.inf);
            r_inf  <= ua.inf | ub.zero;
            r_zero <= ua.zero | ub.inf;
        end else if (r_run) begin
            r_rem <= {diff[24:0], 1'b0};
            r_q   <= {r_q[26:0], ge};
        end
        o_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= 5'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_go) begin
                r_run <= 1'b1;
                r_cnt <= 5'd0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd27) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_nan) begin
            n_res = m4inv_pkg::CANON_NAN;
        end else if (r_inf) begin
            n_res = {r_sgn, 8'hFF, 23'd0};
        end else if (r_zero) begin
            n_res = {r_sgn, 31'd0};
        end else if (r_q[27]) begin
            n_res = m4inv_pkg::round_pack(r_sgn, r_ex, {r_q[27:2], r_q[1] | r_q[0] | st});
        end else begin
            n_res = m4inv_pkg::round_pack(r_sgn, r_ex - 12'sd1, {r_q[26:1], r_q[0] | st});
        end
    end

endmodule

@@ rtl/core/m4inv_datapath.sv @@
// datapath: scratch ram, shared float units and result register
module m4inv_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [31:0]        i_element_bits,
    input  m4inv_pkg::t_cmd    i_cmd,
    output m4inv_pkg::t_stat   o_stat,
    output logic               o_strobe,
    output logic [31:0]        o_result_bits,
    output logic [3:0]         o_result_index,
    output logic               o_last_result
);

    logic        we;
    logic [4:0]  waddr;
    logic [31:0] wdata;
    logic [31:0] ram_a;
    logic [31:0] ram_b;
    logic        r_a_one;
    logic        r_b_one;
    logic [31:0] opa;
    logic [31:0] opb;
    logic        mul_done;
    logic        add_done;
    logic        div_done;
    logic [31:0] mul_res;
    logic [31:0] add_res;
    logic [31:0] div_res;
    logic [31:0] unit_res;

    always_comb begin
        case (i_cmd.op)
            m4inv_pkg::OP_MUL: unit_res = mul_res;
            m4inv_pkg::OP_DIV: unit_res = div_res;
            default:           unit_res = add_res;
        endcase
    end

    assign we    = i_cmd.ld | i_cmd.wr;
    assign waddr = i_cmd.ld ? {1'b0, i_cmd.ld_addr} : i_cmd.dst;
    assign wdata = i_cmd.ld ? i_element_bits : unit_res;

    m4inv_ram #(
        .WIDTH(32),
        .DEPTH(m4inv_pkg::SCR_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_re     (i_cmd.rd),
        .i_raddr_a(i_cmd.ra),
        .i_raddr_b(i_cmd.rb),
        .o_rdata_a(ram_a),
        .o_rdata_b(ram_b)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_a_one <= i_cmd.ra == m4inv_pkg::A_ONE;
            r_b_one <= i_cmd.rb == m4inv_pkg::A_ONE;
        end
    end

    assign opa = (r_a_one ? m4inv_pkg::F_ONE : ram_a) ^ {i_cmd.nega, 31'd0};
    assign opb = r_b_one ? m4inv_pkg::F_ONE : ram_b;

    m4inv_fpmul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (i_cmd.go && i_cmd.op == m4inv_pkg::OP_MUL),
        .i_a    (opa),
        .i_b    (opb),
        .o_done (mul_done),
        .o_res  (mul_res)
    );

    m4inv_fpadd u_add (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (i_cmd.go && (i_cmd.op == m4inv_pkg::OP_ADD ||
                              i_cmd.op == m4inv_pkg::OP_SUB)),
        .i_sub  (i_cmd.op == m4inv_pkg::OP_SUB),
        .i_a    (opa),
        .i_b    (opb),
        .o_done (add_done),
        .o_res  (add_res)
    );

    m4inv_fpdiv u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (i_cmd.go && i_cmd.op == m4inv_pkg::OP_DIV),
        .i_a    (opa),
        .i_b    (opb),
        .o_done (div_done),
        .o_res  (div_res)
    );

    assign o_stat.done = mul_done | add_done | div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            o_result_bits  <= opa;
            o_result_index <= i_cmd.idx;
            o_last_result  <= i_cmd.last;
        end
    end

endmodule

@@ rtl/core/m4inv_ctrl.sv @@
// controller: load counter, mode register and operation sequencer
module m4inv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_wdata,
    input  m4inv_pkg::t_stat  i_stat,
    output m4inv_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_ISSUE = 4'b0100,
        ST_WAIT  = 4'b1000
    } t_state;

    typedef enum logic [7:0] {
        PH_MINOR = 8'b0000_0001,
        PH_DET0  = 8'b0000_0010,
        PH_DETK  = 8'b0000_0100,
        PH_INV   = 8'b0000_1000,
        PH_ADJ   = 8'b0001_0000,
        PH_FDET  = 8'b0010_0000,
        PH_DIVE  = 8'b0100_0000,
        PH_EMITD = 8'b1000_0000
    } t_phase;

    t_state     r_state, n_state;
    t_phase     r_phase, n_phase;
    t_phase     nx_phase;
    logic [4:0] r_idx, n_idx;
    logic [2:0] r_step, n_step;
    logic [3:0] r_count, n_count;
    logic [1:0] r_mode, n_mode;
    logic [1:0] r_op_mode;
    logic [2:0] last_step;
    logic [4:0] last_idx;
    logic       fin;
    logic       adv;
    logic [3:0] i4;
    m4inv_pkg::t_cmd c;

    function automatic logic [4:0] ae(input logic [3:0] k);
        return {1'b0, k};
    endfunction

    function automatic logic [4:0] ab(input logic [3:0] k);
        return {1'b1, k};
    endfunction

    assign i4 = r_idx[3:0];

    // operation for the current phase and step
    always_comb begin
        c      = '0;
        c.op   = m4inv_pkg::OP_MUL;
        c.idx  = i4;
        c.last = 1'b0;
        case (r_phase)
            PH_MINOR: begin
                case (r_step)
                    3'd0: begin
                        c.ra = ae(m4inv_pkg::MINOR_TAB[i4][0]);
                        c.rb = ae(m4inv_pkg::MINOR_TAB[i4][1]);
                        c.dst = m4inv_pkg::A_T;
                    end
                    3'd1: begin
                        c.ra = ae(m4inv_pkg::MINOR_TAB[i4][2]);
                        c.rb = ae(m4inv_pkg::MINOR_TAB[i4][3]);
                        c.dst = m4inv_pkg::A_ACC;
                    end
                    default: begin
                        c.op = m4inv_pkg::OP_SUB;
                        c.ra = m4inv_pkg::A_T;
                        c.rb = m4inv_pkg::A_ACC;
                        c.dst = ab(i4);
                    end
                endcase
            end
            PH_DET0: begin
                case (r_step)
                    3'd0: begin
                        c.ra = ab(4'd0);
                        c.rb = ab(4'd11);
                        c.dst = m4inv_pkg::A_T;
                    end
                    3'd1: begin
                        c.ra = ab(4'd1);
                        c.rb = ab(4'd10);
                        c.dst = m4inv_pkg::A_ACC;
                    end
                    default: begin
                        c.op = m4inv_pkg::OP_SUB;
                        c.ra = m4inv_pkg::A_T;
                        c.rb = m4inv_pkg::A_ACC;
                        c.dst = m4inv_pkg::A_ACC;
                    end
                endcase
            end
            PH_DETK: begin
                case (r_step)
                    3'd0: begin
                        c.ra = ab(m4inv_pkg::DETK_TAB[r_idx[1:0]][0]);
                        c.rb = ab(m4inv_pkg::DETK_TAB[r_idx[1:0]][1]);
                        c.dst = m4inv_pkg::A_T;
                    end
                    default: begin
                        c.op = m4inv_pkg::DETK_SUB[r_idx[1:0]] ? m4inv_pkg::OP_SUB
                                                                : m4inv_pkg::OP_ADD;
                        c.ra = m4inv_pkg::A_ACC;
                        c.rb = m4inv_pkg::A_T;
                        c.dst = m4inv_pkg::A_ACC;
                    end
                endcase
            end
            PH_INV: begin
                c.op  = m4inv_pkg::OP_DIV;
                c.ra  = m4inv_pkg::A_ONE;
                c.rb  = m4inv_pkg::A_ACC;
                c.dst = m4inv_pkg::A_INV;
            end
            PH_ADJ: begin
                case (r_step)
                    3'd0: begin
                        c.ra = ae(m4inv_pkg::ADJ_TAB[i4][0]);
                        c.rb = ab(m4inv_pkg::ADJ_TAB[i4][1]);
                        c.nega = m4inv_pkg::ADJ_NEG[i4];
                        c.dst = m4inv_pkg::A_ACC;
                    end
                    3'd1: begin
                        c.ra = ae(m4inv_pkg::ADJ_TAB[i4][2]);
                        c.rb = ab(m4inv_pkg::ADJ_TAB[i4][3]);
                        c.dst = m4inv_pkg::A_T;
                    end
                    3'd2: begin
                        c.op = m4inv_pkg::ADJ_NEG[i4] ? m4inv_pkg::OP_ADD : m4inv_pkg::OP_SUB;
                        c.ra = m4inv_pkg::A_ACC;
                        c.rb = m4inv_pkg::A_T;
                        c.dst = m4inv_pkg::A_ACC;
                    end
                    3'd3: begin
                        c.ra = ae(m4inv_pkg::ADJ_TAB[i4][4]);
                        c.rb = ab(m4inv_pkg::ADJ_TAB[i4][5]);
                        c.dst = m4inv_pkg::A_T;
                    end
                    3'd4: begin
                        c.op = m4inv_pkg::ADJ_NEG[i4] ? m4inv_pkg::OP_SUB : m4inv_pkg::OP_ADD;
                        c.ra = m4inv_pkg::A_ACC;
                        c.rb = m4inv_pkg::A_T;
                        c.dst = m4inv_pkg::A_ACC;
                    end
                    3'd5: begin
                        c.ra = m4inv_pkg::A_ACC;
                        c.rb = m4inv_pkg::A_INV;
                        c.dst = m4inv_pkg::A_T;
                    end
                    default: begin
                        c.op = m4inv_pkg::OP_EMIT;
                        c.ra = m4inv_pkg::A_T;
                        c.last = i4 == 4'd15;
                    end
                endcase
            end
            PH_FDET: begin
                case (r_step)
                    3'd0: begin
                        c.ra = ae(m4inv_pkg::DET_TERM[r_idx][0]);
                        c.rb = ae(m4inv_pkg::DET_TERM[r_idx][1]);
                        c.dst = m4inv_pkg::A_T;
                    end
                    3'd1: begin
                        c.ra = m4inv_pkg::A_T;
                        c.rb = ae(m4inv_pkg::DET_TERM[r_idx][2]);
                        c.dst = m4inv_pkg::A_T;
                    end
                    3'd2: begin
                        c.ra = m4inv_pkg::A_T;
                        c.rb = ae(m4inv_pkg::DET_TERM[r_idx][3]);
                        c.dst = m4inv_pkg::A_T;
                    end
                    default: begin
                        // first term is moved into the accumulator by a unit multiply
                        if (r_idx == 5'd0) begin
                            c.ra = m4inv_pkg::A_T;
                            c.rb = m4inv_pkg::A_ONE;
                        end else begin
                            c.op = m4inv_pkg::DET_NEG[r_idx] ? m4inv_pkg::OP_SUB
                                                             : m4inv_pkg::OP_ADD;
                            c.ra = m4inv_pkg::A_ACC;
                            c.rb = m4inv_pkg::A_T;
                        end
                        c.dst = m4inv_pkg::A_ACC;
                    end
                endcase
            end
            PH_DIVE: begin
                case (r_step)
                    3'd0: begin
                        c.op = m4inv_pkg::OP_DIV;
                        c.ra = ae(i4);
                        c.rb = m4inv_pkg::A_ACC;
                        c.dst = m4inv_pkg::A_T;
                    end
                    default: begin
                        c.op = m4inv_pkg::OP_EMIT;
                        c.ra = m4inv_pkg::A_T;
                        c.last = i4 == 4'd15;
                    end
                endcase
            end
            default: begin
                c.op   = m4inv_pkg::OP_EMIT;
                c.ra   = m4inv_pkg::A_ACC;
                c.idx  = 4'd0;
                c.last = 1'b1;
            end
        endcase
    end

    // phase limits and successor
    always_comb begin
        last_step = 3'd0;
        last_idx  = 5'd0;
        nx_phase  = r_phase;
        fin       = 1'b0;
        case (r_phase)
            PH_MINOR: begin
                last_step = 3'd2;
                last_idx  = 5'd11;
                nx_phase  = PH_DET0;
            end
            PH_DET0: begin
                last_step = 3'd2;
                nx_phase  = PH_DETK;
            end
            PH_DETK: begin
                last_step = 3'd1;
                last_idx  = 5'd3;
                nx_phase  = PH_INV;
            end
            PH_INV: begin
                nx_phase = PH_ADJ;
            end
            PH_ADJ: begin
                last_step = 3'd6;
                last_idx  = 5'd15;
                fin       = 1'b1;
            end
            PH_FDET: begin
                last_step = 3'd3;
                last_idx  = 5'd23;
                nx_phase  = (r_mode == m4inv_pkg::MODE_DIV) ? PH_DIVE : PH_EMITD;
            end
            PH_DIVE: begin
                last_step = 3'd1;
                last_idx  = 5'd15;
                fin       = 1'b1;
            end
            default: begin
                fin = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_idx   = r_idx;
        n_step  = r_step;
        n_count = r_count;
        n_mode  = r_mode;
        o_cmd   = c;
        adv     = 1'b0;
        o_cmd.ld_addr = r_count;
        case (r_state)
            ST_IDLE: begin
                o_cmd.ld = i_start;
                if (i_start) begin
                    if (r_count == 4'd15) begin
                        n_count = 4'd0;
                        n_mode  = r_op_mode;
                        n_phase = (r_op_mode == m4inv_pkg::MODE_INV) ? PH_MINOR : PH_FDET;
                        n_idx   = 5'd0;
                        n_step  = 3'd0;
                        n_state = ST_READ;
                    end else begin
                        n_count = r_count + 4'd1;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_ISSUE;
            end
            ST_ISSUE: begin
                if (c.op == m4inv_pkg::OP_EMIT) begin
                    o_cmd.emit = 1'b1;
                    adv        = 1'b1;
                    n_state    = ST_READ;
                end else begin
                    o_cmd.go = 1'b1;
                    n_state  = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_stat.done) begin
                    o_cmd.wr = 1'b1;
                    adv      = 1'b1;
                    n_state  = ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (adv) begin
            if (r_step != last_step) begin
                n_step = r_step + 3'd1;
            end else if (r_idx != last_idx) begin
                n_step = 3'd0;
                n_idx  = r_idx + 5'd1;
            end else if (fin) begin
                n_state = ST_IDLE;
            end else begin
                n_step  = 3'd0;
                n_idx   = 5'd0;
                n_phase = nx_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_MINOR;
            r_idx     <= 5'd0;
            r_step    <= 3'd0;
            r_count   <= 4'd0;
            r_mode    <= 2'd0;
            r_op_mode <= 2'd0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_step  <= n_step;
            r_count <= n_count;
            r_mode  <= n_mode;
            if (i_cfg_we) begin
                r_op_mode <= i_cfg_wdata;
            end
        end
    end

    assign o_busy = r_state != ST_IDLE;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.done |-> r_state == ST_WAIT)
        else $error("unit done outside wait");

    a_count_zero_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_count == 4'd0)
        else $error("load count nonzero during compute");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> r_state == ST_IDLE)
        else $error("sequencer did not finish after last result");

    a_full_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start && r_count == 4'd15) |=> r_state == ST_READ)
        else $error("compute did not start after sixteenth element");

endmodule

@@ rtl/core/matrix4_inverse_determinant_core.sv @@
// top level of the 4x4 matrix inverse and determinant core
// loading: one element transfer per cycle, busy stays low through elements 0 to 15
// compute after the sixteenth element: each multiply, add or divide step reads operands,
// issues to one shared unit set and waits for done; a result transfer step reads and emits
// results are one-cycle strobes that the receiver cannot stall
// synchronous active-low reset clears the load counter, the mode register and the sequencer
module matrix4_inverse_determinant_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_element_bits,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    output logic        o_strobe,
    output logic [31:0] o_result_bits,
    output logic [3:0]  o_result_index,
    output logic        o_last_result
);

    m4inv_pkg::t_cmd  cmd;
    m4inv_pkg::t_stat stat;

    m4inv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    m4inv_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_element_bits(i_element_bits),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_strobe      (o_strobe),
        .o_result_bits (o_result_bits),
        .o_result_index(o_result_index),
        .o_last_result (o_last_result)
    );

endmodule
